>>> design/btpc_pkg.sv
package btpc_pkg;

  localparam int unsigned NumCal  = 5;
  localparam int unsigned CalIdxW = 3;
  localparam int unsigned CalW    = 32;

  typedef enum logic [CalIdxW-1:0] {
    CalAc1Ac2 = 3'd0,
    CalAc3Ac4 = 3'd1,
    CalAc5Ac6 = 3'd2,
    CalB1B2   = 3'd3,
    CalMcMd   = 3'd4
  } cal_idx_e;

  localparam logic signed [31:0] B6Offset  = 32'sd4000;
  localparam logic signed [31:0] B4Offset  = 32'sd32768;
  localparam logic        [31:0] B7Scale   = 32'd50000;
  localparam logic signed [31:0] PCoefA    = 32'sd3038;
  localparam logic signed [31:0] PCoefB    = -32'sd7357;
  localparam logic signed [31:0] PCoefC    = 32'sd3791;
  localparam logic signed [31:0] PressMax  = 32'sd1048575;
  localparam logic signed [31:0] TenthsMax = 32'sd32767;
  localparam logic signed [31:0] TenthsMin = -32'sd32768;
  // x/10 == (x * 0xCCCD) >> 19 for x below 81920
  localparam logic [15:0]        Recip10   = 16'hCCCD;
  localparam int unsigned        Recip10Sh = 19;

endpackage

>>> design/btpc_div.sv
module btpc_div #(
  parameter int unsigned DvdW  = 32,
  parameter int unsigned DvsW  = 32,
  parameter int unsigned SideW = 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic [DvdW-1:0]  dividend_i,
  input  logic [DvsW-1:0]  divisor_i,
  input  logic [SideW-1:0] side_i,
  output logic             valid_o,
  output logic [DvdW-1:0]  quotient_o,
  output logic [SideW-1:0] side_o
);

  // one quotient bit per stage, restoring
  logic             vld_q  [DvdW];
  logic [DvdW-1:0]  dvd_q  [DvdW];
  logic [DvsW-1:0]  rem_q  [DvdW];
  logic [DvsW-1:0]  dvs_q  [DvdW];
  logic [SideW-1:0] side_q [DvdW];

  for (genvar g = 0; g < DvdW; g++) begin : g_stage
    logic             vld_in;
    logic [DvdW-1:0]  dvd_in;
    logic [DvsW-1:0]  rem_in;
    logic [DvsW-1:0]  dvs_in;
    logic [SideW-1:0] side_in;
    logic [DvsW:0]    trial;
    logic [DvsW:0]    diff;
    logic             qbit;

    if (g == 0) begin : g_first
      assign vld_in  = valid_i;
      assign dvd_in  = dividend_i;
      assign rem_in  = '0;
      assign dvs_in  = divisor_i;
      assign side_in = side_i;
    end else begin : g_next
      assign vld_in  = vld_q[g-1];
      assign dvd_in  = dvd_q[g-1];
      assign rem_in  = rem_q[g-1];
      assign dvs_in  = dvs_q[g-1];
      assign side_in = side_q[g-1];
    end

    assign trial = {rem_in, dvd_in[DvdW-1]};
    assign diff  = trial - {1'b0, dvs_in};
    assign qbit  = ~diff[DvsW];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[g] <= 1'b0;
      end else if (en_i) begin
        vld_q[g] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        dvd_q[g]  <= {dvd_in[DvdW-2:0], qbit};
        rem_q[g]  <= qbit ? diff[DvsW-1:0] : trial[DvsW-1:0];
        dvs_q[g]  <= dvs_in;
        side_q[g] <= side_in;
      end
    end
  end

  assign valid_o    = vld_q[DvdW-1];
  assign quotient_o = dvd_q[DvdW-1];
  assign side_o     = side_q[DvdW-1];

endmodule

>>> design/baro_temp_pressure_compensation.sv
// Channel   Direction  Handshake                    Payload
// in        sink       in_valid_i / in_stall_o      raw_temp_i, raw_press_i
// out       source     out_valid_o / out_stall_i    temp_tenths_o, temp_degrees_o,
//                                                   pressure_pa_o, calc_error_o
// cfg       sink       cfg_we_i                     cfg_idx_i, cfg_wdata_i
// One transaction per cycle unless the output is stalled; the path runs through the 27-stage
// temperature divider and the 32-stage pressure divider, one quotient bit per stage.
// Reset clears the valid bits and the calibration registers.
// The whole pipeline holds while a result is stalled at the output register.
module baro_temp_pressure_compensation (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [15:0]          raw_temp_i,
  input  logic [15:0]          raw_press_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic signed [15:0]   temp_tenths_o,
  output logic signed [12:0]   temp_degrees_o,
  output logic [19:0]          pressure_pa_o,
  output logic                 calc_error_o,
  input  logic                 cfg_we_i,
  input  logic [btpc_pkg::CalIdxW-1:0] cfg_idx_i,
  input  logic [btpc_pkg::CalW-1:0]    cfg_wdata_i
);

  logic [btpc_pkg::CalW-1:0] cal_q [btpc_pkg::NumCal];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < btpc_pkg::NumCal; i++) cal_q[i] <= '0;
    end else if (cfg_we_i && (cfg_idx_i < btpc_pkg::CalIdxW'(btpc_pkg::NumCal))) begin
      cal_q[cfg_idx_i] <= cfg_wdata_i;
    end
  end

  logic signed [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
  logic [31:0] r_a12, r_a34, r_a56, r_b12, r_mcd;
  assign r_a12 = cal_q[btpc_pkg::CalAc1Ac2];
  assign r_a34 = cal_q[btpc_pkg::CalAc3Ac4];
  assign r_a56 = cal_q[btpc_pkg::CalAc5Ac6];
  assign r_b12 = cal_q[btpc_pkg::CalB1B2];
  assign r_mcd = cal_q[btpc_pkg::CalMcMd];
  assign ac1 = {{16{r_a12[31]}}, r_a12[31:16]};
  assign ac2 = {{16{r_a12[15]}}, r_a12[15:0]};
  assign ac3 = {{16{r_a34[31]}}, r_a34[31:16]};
  assign ac4 = {16'd0, r_a34[15:0]};
  assign ac5 = {16'd0, r_a56[31:16]};
  assign ac6 = {16'd0, r_a56[15:0]};
  assign b1  = {{16{r_b12[31]}}, r_b12[31:16]};
  assign b2  = {{16{r_b12[15]}}, r_b12[15:0]};
  assign mc  = {{16{r_mcd[31]}}, r_mcd[31:16]};
  assign md  = {{16{r_mcd[15]}}, r_mcd[15:0]};

  logic out_valid_q;
  logic en;
  assign en         = !out_valid_q || !out_stall_i;
  assign in_stall_o = !en;

  // S1: UT product
  logic               v1_q;
  logic signed [31:0] prod1_q;
  logic [15:0]        up1_q;
  logic signed [31:0] ut_w;
  assign ut_w = {16'd0, raw_temp_i};

  // S2: X1, divisor magnitude
  logic               v2_q;
  logic signed [31:0] x1_2_q;
  logic [15:0]        up2_q;
  logic               dz2_q, qneg2_q;
  logic [26:0]        dvdm2_q;
  logic [31:0]        dvsm2_q;
  logic signed [31:0] x1_s2, div_s2, mcs_s2, ndvd_s2, ndvs_s2;
  assign x1_s2   = prod1_q >>> 15;
  assign div_s2  = x1_s2 + md;
  assign mcs_s2  = mc <<< 11;
  assign ndvd_s2 = -mcs_s2;
  assign ndvs_s2 = -div_s2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      prod1_q <= (ut_w - ac6) * ac5;
      up1_q   <= raw_press_i;
      x1_2_q  <= x1_s2;
      up2_q   <= up1_q;
      dz2_q   <= (div_s2 == 32'sd0);
      qneg2_q <= mcs_s2[31] ^ div_s2[31];
      dvdm2_q <= mcs_s2[31] ? ndvd_s2[26:0] : mcs_s2[26:0];
      dvsm2_q <= div_s2[31] ? ndvs_s2 : div_s2;
    end
  end

  localparam int unsigned TSideW = 32 + 16 + 2;
  logic              vt;
  logic [26:0]       qt;
  logic [TSideW-1:0] st;
  logic signed [31:0] x1_t;
  logic [15:0]       up_t;
  logic              dz_t, qneg_t;

  btpc_div #(.DvdW(27), .DvsW(32), .SideW(TSideW)) u_tdiv (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v2_q),
    .dividend_i(dvdm2_q), .divisor_i(dvsm2_q),
    .side_i({x1_2_q, up2_q, dz2_q, qneg2_q}),
    .valid_o(vt), .quotient_o(qt), .side_o(st)
  );
  assign {x1_t, up_t, dz_t, qneg_t} = st;

  // S3: B5, T, B6
  logic signed [31:0] qs_3, x2_3, b5_3;
  assign qs_3 = {5'd0, qt};
  assign x2_3 = qneg_t ? -qs_3 : qs_3;
  assign b5_3 = x1_t + x2_3;

  logic               v3_q, v4_q, v5_q, v6_q, v7_q, v8_q;
  logic signed [31:0] b6_3_q, t3_q;
  logic [15:0]        up3_q, up4_q, up5_q, up6_q;
  logic               e3_q, e4_q, e5_q, e6_q, e7_q, e8_q;

  // S4
  logic signed [31:0] sqp4_q, a2p4_q, a3p4_q;
  logic signed [15:0] ten4_q, ten5_q, ten6_q, ten7_q, ten8_q;
  logic signed [31:0] tsat_4;
  assign tsat_4 = (t3_q > btpc_pkg::TenthsMax) ? btpc_pkg::TenthsMax :
                  (t3_q < btpc_pkg::TenthsMin) ? btpc_pkg::TenthsMin : t3_q;

  // S5
  logic signed [31:0] sq_5;
  logic signed [31:0] b2p5_q, b1p5_q, a2p5_q, a3p5_q;
  logic [32:0]        dp5_q;
  logic [16:0]        mag_5;
  logic signed [16:0] ten17_5;
  assign sq_5    = sqp4_q >>> 12;
  assign ten17_5 = {ten4_q[15], ten4_q};
  assign mag_5   = ten4_q[15] ? 17'(-ten17_5) : 17'(ten17_5);

  // S6
  logic signed [31:0] b3_6_q, x3_6_q;
  logic signed [12:0] deg6_q, deg7_q, deg8_q;
  logic signed [31:0] x1_6, x2_6, xa_6, xb_6, b3_6, x3_6;
  logic signed [12:0] dmag_6;
  assign x1_6   = b2p5_q >>> 11;
  assign x2_6   = a2p5_q >>> 11;
  assign b3_6   = ((ac1 <<< 2) + (x1_6 + x2_6) + 32'sd2) >>> 2;
  assign xa_6   = a3p5_q >>> 13;
  assign xb_6   = b1p5_q >>> 16;
  assign x3_6   = ((xa_6 + xb_6) + 32'sd2) >>> 2;
  assign dmag_6 = 13'(dp5_q >> btpc_pkg::Recip10Sh);

  // S7
  logic [31:0] b4p7_q, b7_7_q;
  logic [31:0] up32_7;
  assign up32_7 = {16'd0, up6_q};

  // S8
  logic [31:0] dvd8_q;
  logic [16:0] b4_8_q;
  logic        sh8_q;
  logic [16:0] b4_s8;
  assign b4_s8 = b4p7_q[31:15];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
      v7_q <= 1'b0;
      v8_q <= 1'b0;
    end else if (en) begin
      v3_q <= vt;
      v4_q <= v3_q;
      v5_q <= v4_q;
      v6_q <= v5_q;
      v7_q <= v6_q;
      v8_q <= v7_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      b6_3_q <= b5_3 - btpc_pkg::B6Offset;
      t3_q   <= (b5_3 + 32'sd8) >>> 4;
      up3_q  <= up_t;
      e3_q   <= dz_t;

      sqp4_q <= b6_3_q * b6_3_q;
      a2p4_q <= ac2 * b6_3_q;
      a3p4_q <= ac3 * b6_3_q;
      ten4_q <= tsat_4[15:0];
      up4_q  <= up3_q;
      e4_q   <= e3_q;

      b2p5_q <= b2 * sq_5;
      b1p5_q <= b1 * sq_5;
      a2p5_q <= a2p4_q;
      a3p5_q <= a3p4_q;
      dp5_q  <= 33'(mag_5) * 33'(btpc_pkg::Recip10);
      ten5_q <= ten4_q;
      up5_q  <= up4_q;
      e5_q   <= e4_q;

      b3_6_q <= b3_6;
      x3_6_q <= x3_6;
      deg6_q <= ten5_q[15] ? -dmag_6 : dmag_6;
      ten6_q <= ten5_q;
      up6_q  <= up5_q;
      e6_q   <= e5_q;

      b4p7_q <= ac4 * (x3_6_q + btpc_pkg::B4Offset);
      b7_7_q <= (up32_7 - b3_6_q) * btpc_pkg::B7Scale;
      ten7_q <= ten6_q;
      deg7_q <= deg6_q;
      e7_q   <= e6_q;

      dvd8_q <= b7_7_q[31] ? b7_7_q : (b7_7_q << 1);
      sh8_q  <= !b7_7_q[31];
      b4_8_q <= b4_s8;
      ten8_q <= ten7_q;
      deg8_q <= deg7_q;
      e8_q   <= e7_q || (b4_s8 == 17'd0);
    end
  end

  localparam int unsigned PSideW = 16 + 13 + 2;
  logic              vp;
  logic [31:0]       qp;
  logic [PSideW-1:0] sp;
  logic signed [15:0] ten_p;
  logic signed [12:0] deg_p;
  logic              e_p, sh_p;

  btpc_div #(.DvdW(32), .DvsW(17), .SideW(PSideW)) u_pdiv (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v8_q),
    .dividend_i(dvd8_q), .divisor_i(b4_8_q),
    .side_i({ten8_q, deg8_q, e8_q, sh8_q}),
    .valid_o(vp), .quotient_o(qp), .side_o(sp)
  );
  assign {ten_p, deg_p, e_p, sh_p} = sp;

  // S9, S10, output
  logic signed [31:0] p_9, p8_9;
  assign p_9  = sh_p ? qp : (qp << 1);
  assign p8_9 = p_9 >>> 8;

  logic               v9_q, v10_q;
  logic signed [31:0] p9_q, x1p9_q, x2p9_q, p10_q, x1b10_q, x2_10_q;
  logic signed [15:0] ten9_q, ten10_q;
  logic signed [12:0] deg9_q, deg10_q;
  logic               e9_q, e10_q;

  logic signed [31:0] pf_11, pc_11;
  assign pf_11 = p10_q + (((x1b10_q >>> 16) + x2_10_q + btpc_pkg::PCoefC) >>> 4);
  assign pc_11 = (pf_11 < 32'sd0) ? 32'sd0 :
                 (pf_11 > btpc_pkg::PressMax) ? btpc_pkg::PressMax : pf_11;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v9_q        <= 1'b0;
      v10_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      v9_q        <= vp;
      v10_q       <= v9_q;
      out_valid_q <= v10_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p9_q    <= p_9;
      x1p9_q  <= p8_9 * p8_9;
      x2p9_q  <= btpc_pkg::PCoefB * p_9;
      ten9_q  <= ten_p;
      deg9_q  <= deg_p;
      e9_q    <= e_p;

      p10_q   <= p9_q;
      x1b10_q <= x1p9_q * btpc_pkg::PCoefA;
      x2_10_q <= x2p9_q >>> 16;
      ten10_q <= ten9_q;
      deg10_q <= deg9_q;
      e10_q   <= e9_q;

      temp_tenths_o  <= e10_q ? 16'sd0 : ten10_q;
      temp_degrees_o <= e10_q ? 13'sd0 : deg10_q;
      pressure_pa_o  <= e10_q ? 20'd0 : pc_11[19:0];
      calc_error_o   <= e10_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

>>> design/btpc_checker.sv
module btpc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic signed [15:0] temp_tenths_o,
  input logic signed [12:0] temp_degrees_o,
  input logic [19:0] pressure_pa_o,
  input logic        calc_error_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped under stall");

  a_no_stall_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with empty output");

  a_stall_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i |-> !in_stall_o)
    else $error("input stalled while result taken");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && calc_error_o |->
      temp_tenths_o == 16'sd0 && temp_degrees_o == 13'sd0 && pressure_pa_o == 20'd0)
    else $error("error result not zeroed");

endmodule

bind baro_temp_pressure_compensation btpc_checker u_btpc_checker (
  .clk_i, .rst_ni, .in_stall_o, .out_valid_o, .out_stall_i,
  .temp_tenths_o, .temp_degrees_o, .pressure_pa_o, .calc_error_o
);

>>> test/tb.sv
module tb;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [15:0] ut;
    logic [15:0] up;
  } raw_pair_t;

  typedef struct packed {
    logic signed [15:0] tenths;
    logic signed [12:0] degrees;
    logic [19:0]        press;
    logic               err;
  } comp_res_t;

  localparam int unsigned CycleLimit = 600000;
  localparam int unsigned DrainWait  = 90;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [15:0] raw_temp_i = '0;
  logic [15:0] raw_press_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [15:0] temp_tenths_o;
  logic signed [12:0] temp_degrees_o;
  logic [19:0] pressure_pa_o;
  logic calc_error_o;
  logic cfg_we_i = 1'b0;
  logic [btpc_pkg::CalIdxW-1:0] cfg_idx_i = '0;
  logic [btpc_pkg::CalW-1:0] cfg_wdata_i = '0;

  logic [31:0] cal_words [btpc_pkg::NumCal];
  raw_pair_t   raw_q [$];
  comp_res_t   expected_q [$];
  int          n_fail = 0;
  bit          quiet = 1'b0;
  bit          long_hold_req = 1'b0;

  baro_temp_pressure_compensation u_top (.*);

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic comp_res_t compensate(logic [15:0] ut_raw, logic [15:0] up_raw);
    logic signed [31:0] ac1, ac2, ac3, ac5, ac6, b1, b2, mc, md, ut;
    logic signed [31:0] x1, x2, x3, b3, b5, b6, t, p, dv, sq, tenths, degrees;
    logic [31:0] ac4, b4, b7, sum4, quo;
    comp_res_t r;
    r = '{tenths: '0, degrees: '0, press: '0, err: 1'b1};
    ac1 = $signed(cal_words[btpc_pkg::CalAc1Ac2][31:16]);
    ac2 = $signed(cal_words[btpc_pkg::CalAc1Ac2][15:0]);
    ac3 = $signed(cal_words[btpc_pkg::CalAc3Ac4][31:16]);
    ac4 = {16'h0, cal_words[btpc_pkg::CalAc3Ac4][15:0]};
    ac5 = {16'h0, cal_words[btpc_pkg::CalAc5Ac6][31:16]};
    ac6 = {16'h0, cal_words[btpc_pkg::CalAc5Ac6][15:0]};
    b1 = $signed(cal_words[btpc_pkg::CalB1B2][31:16]);
    b2 = $signed(cal_words[btpc_pkg::CalB1B2][15:0]);
    mc = $signed(cal_words[btpc_pkg::CalMcMd][31:16]);
    md = $signed(cal_words[btpc_pkg::CalMcMd][15:0]);
    ut = {16'h0, ut_raw};

    x1 = ((ut - ac6) * ac5) >>> 15;
    dv = x1 + md;
    if (dv == 0) return r;
    x2 = (mc * 32'sd2048) / dv;
    b5 = x1 + x2;
    t = (b5 + 32'sd8) >>> 4;

    b6 = b5 - btpc_pkg::B6Offset;
    sq = (b6 * b6) >>> 12;
    x1 = (b2 * sq) >>> 11;
    x2 = (ac2 * b6) >>> 11;
    x3 = x1 + x2;
    b3 = ((ac1 * 32'sd4) + x3 + 32'sd2) >>> 2;
    x1 = (ac3 * b6) >>> 13;
    x2 = (b1 * sq) >>> 16;
    x3 = (x1 + x2 + 32'sd2) >>> 2;
    sum4 = x3 + btpc_pkg::B4Offset;
    b4 = (ac4 * sum4) >> 15;
    if (b4 == 0) return r;
    b7 = ({16'h0, up_raw} - b3) * btpc_pkg::B7Scale;
    if (b7 < 32'h8000_0000) quo = (b7 << 1) / b4;
    else quo = (b7 / b4) << 1;
    p = quo;
    x1 = (p >>> 8) * (p >>> 8);
    x1 = (x1 * btpc_pkg::PCoefA) >>> 16;
    x2 = (btpc_pkg::PCoefB * p) >>> 16;
    p = p + ((x1 + x2 + btpc_pkg::PCoefC) >>> 4);

    tenths = t;
    if (tenths > btpc_pkg::TenthsMax) tenths = btpc_pkg::TenthsMax;
    if (tenths < btpc_pkg::TenthsMin) tenths = btpc_pkg::TenthsMin;
    degrees = tenths / 32'sd10;
    if (p < 0) p = 0;
    if (p > btpc_pkg::PressMax) p = btpc_pkg::PressMax;
    r.tenths = tenths[15:0];
    r.degrees = degrees[12:0];
    r.press = p[19:0];
    r.err = 1'b0;
    return r;
  endfunction

  // driver
  int send_gap = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    raw_pair_t nxt;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      send_gap = 0;
    end else if (!in_valid_i || !in_stall_o) begin
      if (in_valid_i) expected_q.push_back(compensate(raw_temp_i, raw_press_i));
      if (send_gap > 0) begin
        send_gap--;
        in_valid_i <= 1'b0;
      end else if (raw_q.size() > 0) begin
        nxt = raw_q.pop_front();
        in_valid_i <= 1'b1;
        raw_temp_i <= nxt.ut;
        raw_press_i <= nxt.up;
        if (!quiet && $urandom_range(0, 9) == 0) send_gap = $urandom_range(1, 14);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // monitor and output stall
  int rx_gap = 0;
  int rx_hold = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    comp_res_t exp_r;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          $error("unexpected transaction: tenths %0d press %0d err %0b",
                 temp_tenths_o, pressure_pa_o, calc_error_o);
          n_fail++;
        end else begin
          exp_r = expected_q.pop_front();
          if (temp_tenths_o !== exp_r.tenths) begin
            $error("temp_tenths exp %0d got %0d", exp_r.tenths, temp_tenths_o);
            n_fail++;
          end
          if (temp_degrees_o !== exp_r.degrees) begin
            $error("temp_degrees exp %0d got %0d", exp_r.degrees, temp_degrees_o);
            n_fail++;
          end
          if (pressure_pa_o !== exp_r.press) begin
            $error("pressure_pa exp %0d got %0d", exp_r.press, pressure_pa_o);
            n_fail++;
          end
          if (calc_error_o !== exp_r.err) begin
            $error("calc_error exp %0b got %0b", exp_r.err, calc_error_o);
            n_fail++;
          end
        end
      end
      if (rx_hold > 0) begin
        rx_hold--;
        out_stall_i <= 1'b1;
      end else if (long_hold_req) begin
        long_hold_req = 1'b0;
        rx_hold = 400;
        out_stall_i <= 1'b1;
      end else if (rx_gap > 0) begin
        rx_gap--;
        out_stall_i <= 1'b1;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        rx_gap = $urandom_range(0, 13);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  int unsigned cycles = 0;
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic cal_write(int idx, logic [31:0] data);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx[btpc_pkg::CalIdxW-1:0];
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx < btpc_pkg::NumCal) cal_words[idx] = data;
  endtask

  task automatic cal_load(logic [31:0] w0, w1, w2, w3, w4);
    cal_write(btpc_pkg::CalAc1Ac2, w0);
    cal_write(btpc_pkg::CalAc3Ac4, w1);
    cal_write(btpc_pkg::CalAc5Ac6, w2);
    cal_write(btpc_pkg::CalB1B2, w3);
    cal_write(btpc_pkg::CalMcMd, w4);
  endtask

  task automatic drain();
    while (raw_q.size() > 0 || in_valid_i || expected_q.size() > 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  task automatic push_raw(logic [15:0] ut, logic [15:0] up);
    raw_q.push_back('{ut: ut, up: up});
  endtask

  // realistic readings around the datasheet point, otherwise full range
  task automatic push_random(int n);
    repeat (n) begin
      if ($urandom_range(0, 1))
        push_raw(16'($urandom_range(20000, 36000)), 16'($urandom_range(15000, 40000)));
      else
        push_raw(16'($urandom), 16'($urandom));
    end
  endtask

  function automatic logic [15:0] jitter(logic [15:0] v, int span);
    return v + 16'($urandom_range(0, 2 * span)) - 16'(span);
  endfunction

  localparam logic [31:0] DsAc12 = {16'sd408, -16'sd72};
  localparam logic [31:0] DsAc34 = {-16'sd14383, 16'd32741};
  localparam logic [31:0] DsAc56 = {16'd32757, 16'd23153};
  localparam logic [31:0] DsB12  = {16'sd6190, 16'sd4};
  localparam logic [31:0] DsMcMd = {-16'sd8711, 16'sd2868};

  initial begin
    for (int i = 0; i < btpc_pkg::NumCal; i++) cal_words[i] = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset calibration: temperature divisor is zero
    push_raw(16'd27898, 16'd23843);
    push_raw(16'hFFFF, 16'h0000);
    drain();

    cal_load(DsAc12, DsAc34, DsAc56, DsB12, DsMcMd);
    for (int i = btpc_pkg::NumCal; i < 8; i++) cal_write(i, $urandom);
    push_raw(16'd27898, 16'd23843);
    push_raw(16'h0000, 16'h0000);
    push_raw(16'hFFFF, 16'hFFFF);
    push_raw(16'h0000, 16'hFFFF);
    push_raw(16'hFFFF, 16'h0000);
    push_raw(16'h8000, 16'h5555);
    push_raw(16'h7FFF, 16'hAAAA);
    push_raw(16'd23153, 16'd30000);
    drain();

    // temperature divisor zero at UT == AC6
    cal_write(btpc_pkg::CalMcMd, {-16'sd8711, 16'sd0});
    push_raw(16'd23153, 16'd23843);
    push_raw(16'd23154, 16'd23843);
    drain();

    // pressure divisor zero: AC4 = 0
    cal_write(btpc_pkg::CalMcMd, DsMcMd);
    cal_write(btpc_pkg::CalAc3Ac4, {-16'sd14383, 16'd0});
    push_raw(16'd27898, 16'd23843);
    push_raw(16'd30000, 16'hFFFF);
    drain();

    cal_load('1, '1, '1, '1, '1);
    push_raw(16'h0000, 16'h0000);
    push_raw(16'hFFFF, 16'hFFFF);
    push_raw(16'h1234, 16'hFEDC);
    drain();
    cal_load(32'h7FFF_8000, 32'h8000_FFFF, 32'hFFFF_0000, 32'h7FFF_8000, 32'h8000_7FFF);
    push_raw(16'h0000, 16'hFFFF);
    push_raw(16'hFFFF, 16'h0000);
    push_raw(16'h8000, 16'h8000);
    drain();

    for (int ph = 0; ph < 9; ph++) begin
      if (ph % 3 == 2)
        cal_load($urandom, $urandom, $urandom, $urandom, $urandom);
      else
        cal_load({jitter(DsAc12[31:16], 300), jitter(DsAc12[15:0], 300)},
                 {jitter(DsAc34[31:16], 2000), jitter(DsAc34[15:0], 2000)},
                 {jitter(DsAc56[31:16], 2000), jitter(DsAc56[15:0], 2000)},
                 {jitter(DsB12[31:16], 1000), jitter(DsB12[15:0], 10)},
                 {jitter(DsMcMd[31:16], 1000), jitter(DsMcMd[15:0], 500)});
      if (ph == 8) quiet = 1'b1;
      if (ph == 3) long_hold_req = 1'b1;
      push_random(110);
      drain();
    end

    if (n_fail == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
